/* hdl/kad_pkg.sv */
// shared constants for the keyed anomaly detector
`default_nettype none

package kad_pkg;

  // table geometry: depth is a power of two, so the slot is the low key bits
  localparam int TABLE_AW    = 16;
  localparam int TABLE_DEPTH = 1 << TABLE_AW;
  localparam int ENTRY_W     = 64;
  localparam int CNT_W       = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;

  typedef logic [TABLE_AW-1:0] tbl_idx_t;
  typedef logic [ENTRY_W-1:0]  tbl_entry_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  localparam tbl_idx_t TBL_LAST_IDX = {TABLE_AW{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECIDE_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANOMALY_LIMIT = 4'd1;

  localparam logic [CFG_DATA_W-1:0] DECIDE_COUNT_RST  = 16'd24;
  localparam logic [CFG_DATA_W-1:0] ANOMALY_LIMIT_RST = 16'd4;

  // outcome codes
  localparam logic [2:0] OUT_NONE         = 3'd0;
  localparam logic [2:0] OUT_TRUE_ANOMALY = 3'd1;
  localparam logic [2:0] OUT_FALSE_ANOMALY = 3'd2;
  localparam logic [2:0] OUT_TRUE_NORMAL  = 3'd3;
  localparam logic [2:0] OUT_MISSED       = 3'd4;

endpackage

`default_nettype wire

/* hdl/keyed_anomaly_detector.sv */
// keyed anomaly detector: per-key hit/sum table with verdict counters
//
// usage
//   input channel (in_valid/in_ready): one packet per transaction, a 64-bit
//   key, an 8-bit value and a truth flag. the low TABLE_AW key bits pick a
//   table entry holding {hit count, value sum}, which is bumped by one hit
//   and the value. when the new hit count equals decide_count, the sum is
//   judged (at or below anomaly_limit is an anomaly) and crossed with the
//   flag to bump one of four outcome counters.
//   output channel (out_valid/out_ready): one result transaction per packet,
//   with the updated entry, the outcome code and all six counters.
//   config channel (cfg_valid/cfg_ready): always ready, index 0 decide_count,
//   index 1 anomaly_limit, other indexes are ignored.
// sequencing
//   a packet is read from the table when it is accepted (synchronous ram,
//   registered read), then added, judged and written back in the update
//   state. the read of the next packet only starts after the write, so the
//   same entry never overlaps. the result is registered at the write-back.
// reset and stall
//   after reset a clearing pass writes zero to all TABLE_DEPTH (65536)
//   entries, one per cycle; in_ready stays low during it. when the receiver
//   stalls, the result waits in the output register and the next packet is
//   accepted and read, then holds until the output register frees up.
`default_nettype none

module keyed_anomaly_detector import kad_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // packet input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [63:0]           in_key,
  input  wire logic [7:0]            in_value,
  input  wire logic                  in_truth_flag,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [31:0]                out_hit_count,
  output logic [31:0]                out_value_sum,
  output logic [2:0]                 out_outcome,
  output logic [31:0]                out_decisions_total,
  output logic [31:0]                out_true_anomalies,
  output logic [31:0]                out_false_anomalies,
  output logic [31:0]                out_true_normals,
  output logic [31:0]                out_missed_anomalies,
  output logic [31:0]                out_flagged_packets,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;  // zeroing the table after reset
  localparam logic [1:0] ST_IDLE  = 2'd1;  // waiting for a packet
  localparam logic [1:0] ST_RD    = 2'd2;  // read data back, update and write

  logic [1:0] state_r, state_nxt;
  tbl_idx_t   clr_idx_r, clr_idx_nxt;

  // configuration registers
  logic [CFG_DATA_W-1:0] decide_count_r, decide_count_nxt;
  logic [CFG_DATA_W-1:0] anomaly_limit_r, anomaly_limit_nxt;

  // captured packet fields
  tbl_idx_t   idx_r;
  logic [7:0] value_r;
  logic       flag_r;

  // table memory
  tbl_entry_t table_mem [TABLE_DEPTH];
  tbl_entry_t rdata_r;
  logic       mem_we;
  tbl_idx_t   mem_waddr;
  tbl_entry_t mem_wdata;

  // counters and output registers
  cnt_t decisions_r, decisions_nxt;
  cnt_t true_anom_r, true_anom_nxt;
  cnt_t false_anom_r, false_anom_nxt;
  cnt_t true_norm_r, true_norm_nxt;
  cnt_t missed_r, missed_nxt;
  cnt_t flagged_r, flagged_nxt;
  logic out_valid_r, out_valid_nxt;
  cnt_t hit_count_r;
  cnt_t value_sum_r;
  logic [2:0] outcome_r, outcome_nxt;

  logic       in_acc;
  logic       load_w;
  tbl_entry_t entry_new;
  cnt_t       hits_new;
  cnt_t       sum_new;
  logic       decide_hit;
  logic       is_anomaly;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // result can be loaded when the output slot is empty or being drained
  assign load_w = (state_r == ST_RD) && (!out_valid_r || out_ready);

  // one 64-bit add: carry out of the sum rolls into the hit count
  assign entry_new  = rdata_r + {32'd1, 24'd0, value_r};
  assign hits_new   = entry_new[ENTRY_W-1:CNT_W];
  assign sum_new    = entry_new[CNT_W-1:0];
  assign decide_hit = (hits_new == {16'd0, decide_count_r});
  assign is_anomaly = (sum_new <= {16'd0, anomaly_limit_r});

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + tbl_idx_t'(1);
        if (clr_idx_r == TBL_LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (load_w) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // memory write port: clearing pass or read-modify-write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = entry_new;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else if (load_w) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rdata_r <= table_mem[in_key[TABLE_AW-1:0]];
    end
  end

  // configuration decode
  always_comb begin
    decide_count_nxt  = decide_count_r;
    anomaly_limit_nxt = anomaly_limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECIDE_COUNT:  decide_count_nxt  = cfg_data;
        REG_ANOMALY_LIMIT: anomaly_limit_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // verdict and counter updates, applied only when the result is loaded
  always_comb begin
    decisions_nxt  = decisions_r;
    true_anom_nxt  = true_anom_r;
    false_anom_nxt = false_anom_r;
    true_norm_nxt  = true_norm_r;
    missed_nxt     = missed_r;
    flagged_nxt    = flagged_r;
    outcome_nxt    = OUT_NONE;
    out_valid_nxt  = out_valid_r && !out_ready;
    if (load_w) begin
      out_valid_nxt = 1'b1;
      if (flag_r) begin
        flagged_nxt = flagged_r + cnt_t'(1);
      end
      if (decide_hit) begin
        decisions_nxt = decisions_r + cnt_t'(1);
        if (is_anomaly && flag_r) begin
          true_anom_nxt = true_anom_r + cnt_t'(1);
          outcome_nxt   = OUT_TRUE_ANOMALY;
        end else if (is_anomaly) begin
          false_anom_nxt = false_anom_r + cnt_t'(1);
          outcome_nxt    = OUT_FALSE_ANOMALY;
        end else if (flag_r) begin
          missed_nxt  = missed_r + cnt_t'(1);
          outcome_nxt = OUT_MISSED;
        end else begin
          true_norm_nxt = true_norm_r + cnt_t'(1);
          outcome_nxt   = OUT_TRUE_NORMAL;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      clr_idx_r       <= '0;
      decide_count_r  <= DECIDE_COUNT_RST;
      anomaly_limit_r <= ANOMALY_LIMIT_RST;
      decisions_r     <= '0;
      true_anom_r     <= '0;
      false_anom_r    <= '0;
      true_norm_r     <= '0;
      missed_r        <= '0;
      flagged_r       <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_idx_r       <= clr_idx_nxt;
      decide_count_r  <= decide_count_nxt;
      anomaly_limit_r <= anomaly_limit_nxt;
      decisions_r     <= decisions_nxt;
      true_anom_r     <= true_anom_nxt;
      false_anom_r    <= false_anom_nxt;
      true_norm_r     <= true_norm_nxt;
      missed_r        <= missed_nxt;
      flagged_r       <= flagged_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r   <= in_key[TABLE_AW-1:0];
      value_r <= in_value;
      flag_r  <= in_truth_flag;
    end
    if (load_w) begin
      hit_count_r <= hits_new;
      value_sum_r <= sum_new;
      outcome_r   <= outcome_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hit_count        = hit_count_r;
  assign out_value_sum        = value_sum_r;
  assign out_outcome          = outcome_r;
  assign out_decisions_total  = decisions_r;
  assign out_true_anomalies   = true_anom_r;
  assign out_false_anomalies  = false_anom_r;
  assign out_true_normals     = true_norm_r;
  assign out_missed_anomalies = missed_r;
  assign out_flagged_packets  = flagged_r;

`ifndef ASSERT_OFF
  // a stalled result keeps its counters frozen
  a_stall_counters: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(decisions_r) && $stable(flagged_r))
    else $error("counters moved while result stalled");

  // no second read before the write-back of the current packet
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("packet accepted while read-modify-write in flight");

  // every verdict bumps the decision counter by exactly one
  a_decision_step: assert property (@(posedge clk) disable iff (!rst_n)
    load_w && decide_hit |=> decisions_r == $past(decisions_r) + cnt_t'(1))
    else $error("decision counter out of step with verdict");

  // a new result only appears after the update cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_RD)
    else $error("result without table update");
`endif

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench for keyed_anomaly_detector: scoreboard check of every result against a packet model
`timescale 1ns / 1ps

module testbench;
  import kad_pkg::*;

  // one packet as the driver presents it
  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  value;
    logic        flag;
  } packet_t;

  // everything one result transaction carries
  typedef struct packed {
    cnt_t       hit_count;
    cnt_t       value_sum;
    logic [2:0] outcome;
    cnt_t       decisions;
    cnt_t       true_anom;
    cnt_t       false_anom;
    cnt_t       true_norm;
    cnt_t       missed;
    cnt_t       flagged;
  } det_result_t;

  localparam logic [63:0] ONE_HIT = 64'h1_0000_0000;
  localparam int GAP_PCT = 20;
  localparam int MAX_PRINTS = 100;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [63:0]           in_key = '0;
  logic [7:0]            in_value = '0;
  logic                  in_truth_flag = 1'b0;

  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           out_hit_count;
  logic [31:0]           out_value_sum;
  logic [2:0]            out_outcome;
  logic [31:0]           out_decisions_total;
  logic [31:0]           out_true_anomalies;
  logic [31:0]           out_false_anomalies;
  logic [31:0]           out_true_normals;
  logic [31:0]           out_missed_anomalies;
  logic [31:0]           out_flagged_packets;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // packets waiting for the driver, results waiting for the monitor
  packet_t     packet_q[$];
  det_result_t pending_results[$];

  // model state: the table, the six counters and the two registers
  bit [ENTRY_W-1:0]    slot_table [TABLE_DEPTH];
  cnt_t                n_decisions = '0;
  cnt_t                n_true_anom = '0;
  cnt_t                n_false_anom = '0;
  cnt_t                n_true_norm = '0;
  cnt_t                n_missed = '0;
  cnt_t                n_flagged = '0;
  logic [CFG_DATA_W-1:0] cur_decide = DECIDE_COUNT_RST;
  logic [CFG_DATA_W-1:0] cur_limit  = ANOMALY_LIMIT_RST;

  // slots already handed out to stimulus, so bursts start from a clean entry
  bit slot_taken [TABLE_DEPTH];

  int  mismatches = 0;
  bit  no_gaps = 1'b0;

  keyed_anomaly_detector uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_key               (in_key),
    .in_value             (in_value),
    .in_truth_flag        (in_truth_flag),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_hit_count        (out_hit_count),
    .out_value_sum        (out_value_sum),
    .out_outcome          (out_outcome),
    .out_decisions_total  (out_decisions_total),
    .out_true_anomalies   (out_true_anomalies),
    .out_false_anomalies  (out_false_anomalies),
    .out_true_normals     (out_true_normals),
    .out_missed_anomalies (out_missed_anomalies),
    .out_flagged_packets  (out_flagged_packets),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #2 clk = ~clk;

  // bump the entry, judge it at the decide count, update the counters
  function automatic det_result_t score_packet(logic [63:0] key, logic [7:0] val,
                                               logic flag);
    tbl_idx_t    slot;
    logic [63:0] entry;
    det_result_t r;
    slot = key[TABLE_AW-1:0];
    if (flag) n_flagged++;
    // single 64-bit add, a carry out of the sum lands in the hit count
    entry = slot_table[slot] + ONE_HIT + {56'd0, val};
    slot_table[slot] = entry;
    r.hit_count = entry[63:32];
    r.value_sum = entry[31:0];
    r.outcome = OUT_NONE;
    // register compared as written, so zero only matches after a wrap
    if (r.hit_count == {16'd0, cur_decide}) begin
      n_decisions++;
      if (r.value_sum <= {16'd0, cur_limit}) begin
        if (flag) begin
          n_true_anom++;
          r.outcome = OUT_TRUE_ANOMALY;
        end else begin
          n_false_anom++;
          r.outcome = OUT_FALSE_ANOMALY;
        end
      end else begin
        if (flag) begin
          n_missed++;
          r.outcome = OUT_MISSED;
        end else begin
          n_true_norm++;
          r.outcome = OUT_TRUE_NORMAL;
        end
      end
    end
    r.decisions  = n_decisions;
    r.true_anom  = n_true_anom;
    r.false_anom = n_false_anom;
    r.true_norm  = n_true_norm;
    r.missed     = n_missed;
    r.flagged    = n_flagged;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatches < MAX_PRINTS)
      $display("testbench: mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  function automatic tbl_idx_t pick_fresh_slot();
    tbl_idx_t s;
    do
      s = tbl_idx_t'($urandom_range(0, TABLE_DEPTH - 1));
    while (slot_taken[s]);
    slot_taken[s] = 1'b1;
    return s;
  endfunction

  // random upper bits over a chosen slot, the upper bits only alias
  function automatic logic [63:0] make_key(tbl_idx_t s);
    logic [63:0] k;
    k = {$urandom, $urandom};
    k[TABLE_AW-1:0] = s;
    return k;
  endfunction

  function automatic void queue_packet(logic [63:0] key, logic [7:0] val, logic flag);
    packet_t p;
    p.key = key;
    p.value = val;
    p.flag = flag;
    slot_taken[key[TABLE_AW-1:0]] = 1'b1;
    packet_q.push_back(p);
  endfunction

  // input driver: a new transaction only once the previous one is taken
  always @(posedge clk) begin : drv
    packet_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        pending_results.push_back(score_packet(in_key, in_value, in_truth_flag));
      if (!in_valid || in_ready) begin
        if (packet_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
          nxt = packet_q.pop_front();
          in_valid      <= 1'b1;
          in_key        <= nxt.key;
          in_value      <= nxt.value;
          in_truth_flag <= nxt.flag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back pressure, in-order compare against the model
  always @(posedge clk) begin : mon
    det_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("hit_count", out_hit_count, want.hit_count);
          check_field("value_sum", out_value_sum, want.value_sum);
          check_field("outcome", {29'd0, out_outcome}, {29'd0, want.outcome});
          check_field("decisions_total", out_decisions_total, want.decisions);
          check_field("true_anomalies", out_true_anomalies, want.true_anom);
          check_field("false_anomalies", out_false_anomalies, want.false_anom);
          check_field("true_normals", out_true_normals, want.true_norm);
          check_field("missed_anomalies", out_missed_anomalies, want.missed);
          check_field("flagged_packets", out_flagged_packets, want.flagged);
        end
      end
      out_ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  // one register write transaction, valid is left high for back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DECIDE_COUNT:  cur_decide = data;
      REG_ANOMALY_LIMIT: cur_limit = data;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] dc, logic [CFG_DATA_W-1:0] lim);
    @(posedge clk);
    write_reg(REG_DECIDE_COUNT, dc);
    write_reg(REG_ANOMALY_LIMIT, lim);
    // unmapped indexes must leave both registers alone
    if ($urandom_range(0, 1) != 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_ANOMALY_LIMIT + 1, (1 << CFG_IDX_W) - 1)),
                CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // settle on the falling edge so the driver and monitor have finished the step
  task automatic wait_drained();
    do
      @(negedge clk);
    while (packet_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // interleaved bursts on fresh slots mostly reach a decide count of 1 to 12, the
  // rest is noise and bursts cut short
  task automatic add_random(int count, logic [CFG_DATA_W-1:0] dc);
    tbl_idx_t    burst_slot [4];
    int          burst_left [4];
    logic        burst_flag [4];
    int          i;
    logic [7:0]  val;
    logic        flag;
    for (i = 0; i < 4; i++) burst_left[i] = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_packet({$urandom, $urandom}, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end else begin
        i = $urandom_range(0, 3);
        if (burst_left[i] == 0) begin
          burst_slot[i] = pick_fresh_slot();
          if (dc >= 1 && dc <= 12 && $urandom_range(0, 9) != 0)
            burst_left[i] = dc;
          else
            burst_left[i] = $urandom_range(1, 12);
          burst_flag[i] = 1'($urandom_range(0, 1));
        end
        // mostly small values so the sums land near the limit
        if ($urandom_range(0, 2) != 0)
          val = 8'($urandom_range(0, 3));
        else
          val = 8'($urandom_range(0, 255));
        flag = ($urandom_range(0, 9) == 0) ? !burst_flag[i] : burst_flag[i];
        queue_packet(make_key(burst_slot[i]), val, flag);
        burst_left[i]--;
      end
    end
  endtask

  // stimulus and phase sequencing
  initial begin : stim
    tbl_idx_t s;
    tbl_idx_t t;
    logic [CFG_DATA_W-1:0] dc;
    logic [CFG_DATA_W-1:0] lim;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: key extremes, value extremes, upper key bits aliasing slot 0
    queue_packet(64'd0, 8'd0, 1'b0);
    queue_packet({64{1'b1}}, 8'hFF, 1'b1);
    queue_packet(64'h8000_0000_0000_0000, 8'hAA, 1'b0);
    queue_packet(64'h5555_5555_5555_5555, 8'h55, 1'b1);
    wait_drained();

    // decide on the first hit with a zero limit: all four outcomes, then a
    // back-to-back hit on the same slot that must not decide again
    set_config(16'd1, 16'd0);
    s = pick_fresh_slot();
    queue_packet(make_key(s), 8'd0, 1'b1);
    s = pick_fresh_slot();
    queue_packet(make_key(s), 8'd0, 1'b0);
    s = pick_fresh_slot();
    queue_packet(make_key(s), 8'd1, 1'b0);
    s = pick_fresh_slot();
    queue_packet(make_key(s), 8'd1, 1'b1);
    queue_packet(make_key(s), 8'd0, 1'b1);
    wait_drained();

    // widest limit, two interleaved keys decided on their second hit
    set_config(16'd2, 16'hFFFF);
    s = pick_fresh_slot();
    t = pick_fresh_slot();
    queue_packet(make_key(s), 8'hFF, 1'b0);
    queue_packet(make_key(t), 8'd7, 1'b1);
    queue_packet(make_key(s), 8'hFF, 1'b1);
    queue_packet(make_key(t), 8'd0, 1'b0);
    wait_drained();

    // random phases, each with its own register setting
    for (int k = 0; k < RAND_PHASES; k++) begin
      case (k)
        0: begin
          dc = 16'd1;
          lim = CFG_DATA_W'($urandom_range(0, 3));
        end
        1: begin
          dc = 16'hFFFF;
          lim = CFG_DATA_W'($urandom_range(0, 40));
        end
        2: begin
          dc = 16'd0;
          lim = 16'hFFFF;
        end
        3: begin
          dc = CFG_DATA_W'($urandom_range(2, 12));
          lim = 16'hFFFF;
        end
        4: begin
          dc = CFG_DATA_W'($urandom_range(2, 12));
          lim = 16'd0;
        end
        default: begin
          dc = CFG_DATA_W'($urandom_range(1, 12));
          lim = CFG_DATA_W'($urandom_range(0, 40));
        end
      endcase
      set_config(dc, lim);
      // one whole phase at full rate on both sides
      no_gaps = (k == 6);
      add_random(PHASE_ITEMS, dc);
      wait_drained();
    end
    no_gaps = 1'b0;

    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // covers the table clearing pass after reset with a wide margin
  initial begin : watchdog
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
